// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL modules; included by nsd_parse.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/nsd_pkg.sv =====
package nsd_pkg;

    // Default width of the length accumulator and payload counter
    localparam int LENGTH_BITS_DEF = 30;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int ERR_W    = 3;
    localparam int FB_W     = 30;
    localparam int DIGITS_W = 4;
    localparam int MAXPL_W  = 30;
    localparam int TDATA_W  = 48;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd3;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NO_PREFIX = 3'd1;
    localparam logic [ERR_W-1:0] ERR_TOO_LONG  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_NO_COLON  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_LEAD_ZERO = 3'd4;
    localparam logic [ERR_W-1:0] ERR_TOO_LARGE = 3'd5;
    localparam logic [ERR_W-1:0] ERR_NO_COMMA  = 3'd6;

    // Register indexes (word address bit 2)
    localparam logic REG_MAX_DIGITS  = 1'b0;
    localparam logic REG_MAX_PAYLOAD = 1'b1;

    // Register reset values
    localparam logic [DIGITS_W-1:0] MAX_DIGITS_RST  = 4'd9;
    localparam logic [MAXPL_W-1:0]  MAX_PAYLOAD_RST = 30'd1048576;

    // Characters and digit limit
    localparam logic [BYTE_W-1:0]   CH_COLON    = 8'h3A;
    localparam logic [BYTE_W-1:0]   CH_COMMA    = 8'h2C;
    localparam logic [BYTE_W-1:0]   CH_ZERO     = 8'h30;
    localparam logic [BYTE_W-1:0]   CH_NINE     = 8'h39;
    localparam logic [DIGITS_W-1:0] DIGIT_LIMIT = 4'd9;

    typedef struct packed {
        logic [DIGITS_W-1:0] max_digits;
        logic [MAXPL_W-1:0]  max_payload;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [ERR_W-1:0]  err;
        logic [FB_W-1:0]   fbytes;
    } t_result;

endpackage

// ===== rtl/core/netstring_deframer_unit.sv =====
// The byte in the input register is parsed into the result register: one byte
// per cycle while m_tready is high. The frame state register closes the only
// loop, with one multiply-by-ten add and compare per byte.
// Each byte gives exactly one result word; downstream stalls back up through
// the input register. Reset (synchronous, active low) empties both registers,
// returns the parser to awaiting a prefix and restores the register defaults.
module netstring_deframer_unit #(
    parameter int LENGTH_BITS = nsd_pkg::LENGTH_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Byte stream in
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [nsd_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] rx_byte
    // Result stream out
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [nsd_pkg::TDATA_W-1:0] m_tdata,   // [7:0] data_byte, [10:8] error_code,
                                                   // [40:11] frame_bytes, [47:41] zero
    output logic [nsd_pkg::KIND_W-1:0]  m_tuser,   // [1:0] result_kind
    output logic                        m_tlast,   // payload_last
    // Register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nsd_pkg::APB_AW-1:0]  paddr,
    input  logic [nsd_pkg::APB_DW-1:0]  pwdata,
    output logic [nsd_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import nsd_pkg::*;

    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_vld;
    t_result           r_out;
    t_result           res;
    t_cfg              cfg;
    logic              adv;

    nsd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    nsd_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // Advance when a byte is held and the result register frees up
    assign adv      = r_in_vld && (!r_out_vld || m_tready);
    assign s_tready = !r_in_vld || adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_byte <= s_tdata;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tuser  = r_out.kind;
    assign m_tlast  = r_out.last;
    assign m_tdata  = {{(TDATA_W-FB_W-ERR_W-BYTE_W){1'b0}}, r_out.fbytes, r_out.err, r_out.data};

endmodule

// ===== rtl/core/nsd_cfg.sv =====
module nsd_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nsd_pkg::APB_AW-1:0]  paddr,
    input  logic [nsd_pkg::APB_DW-1:0]  pwdata,
    output logic [nsd_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output nsd_pkg::t_cfg               o_cfg
);
    import nsd_pkg::*;

    logic [DIGITS_W-1:0] r_max_digits;
    logic [MAXPL_W-1:0]  r_max_payload;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_digits  <= MAX_DIGITS_RST;
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (wr_en) begin
            if (paddr[2] == REG_MAX_DIGITS) begin
                r_max_digits <= pwdata[DIGITS_W-1:0];
            end else begin
                r_max_payload <= pwdata[MAXPL_W-1:0];
            end
        end
    end

    // Read back
    always_comb begin
        if (paddr[2] == REG_MAX_PAYLOAD) begin
            prdata = {{(APB_DW-MAXPL_W){1'b0}}, r_max_payload};
        end else begin
            prdata = {{(APB_DW-DIGITS_W){1'b0}}, r_max_digits};
        end
    end

    assign o_cfg.max_digits  = r_max_digits;
    assign o_cfg.max_payload = r_max_payload;

endmodule

// ===== rtl/core/nsd_parse.sv =====
`include "assert_macros.svh"

module nsd_parse #(
    parameter int LENGTH_BITS = nsd_pkg::LENGTH_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic [nsd_pkg::BYTE_W-1:0]    i_byte,
    input  nsd_pkg::t_cfg                 i_cfg,
    output nsd_pkg::t_result              o_res
);
    import nsd_pkg::*;

    localparam int MULW = LENGTH_BITS + 4;
    localparam int SUMW = (LENGTH_BITS + 1 > FB_W) ? LENGTH_BITS + 1 : FB_W;
    localparam int CMPW = (LENGTH_BITS > MAXPL_W) ? LENGTH_BITS : MAXPL_W;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PREFIX,
        PH_PAYLOAD,
        PH_COMMA
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [DIGITS_W-1:0]    r_digit_cnt, n_digit_cnt;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic                   r_first_zero, n_first_zero;
    logic [LENGTH_BITS-1:0] r_left, n_left;
    logic                   r_ovf, n_ovf;

    logic                   is_dig;
    logic [3:0]             dig;
    logic [DIGITS_W-1:0]    limit;
    logic [MULW-1:0]        len_mul;
    logic                   mul_ovf;
    logic [LENGTH_BITS-1:0] left_dec;
    logic [SUMW-1:0]        total;
    logic                   fail;
    logic [ERR_W-1:0]       fail_code;

    // Decode the byte and the digit limit
    always_comb begin
        is_dig = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        dig    = is_dig ? 4'(i_byte - CH_ZERO) : 4'd0;
        limit  = (i_cfg.max_digits > DIGIT_LIMIT) ? DIGIT_LIMIT : i_cfg.max_digits;
    end

    // Multiply by ten as (x << 3) + (x << 1), then add the digit
    assign len_mul = (MULW'(r_len) << 3) + (MULW'(r_len) << 1) + MULW'(dig);
    assign mul_ovf = |len_mul[MULW-1:LENGTH_BITS];
    assign left_dec = r_left - LENGTH_BITS'(1);
    assign total    = SUMW'(r_digit_cnt) + SUMW'(2) + SUMW'(r_len);

    // Next state and result for the byte in the input register
    always_comb begin
        n_phase      = r_phase;
        n_digit_cnt  = r_digit_cnt;
        n_len        = r_len;
        n_first_zero = r_first_zero;
        n_left       = r_left;
        n_ovf        = r_ovf;
        fail         = 1'b0;
        fail_code    = ERR_NONE;
        o_res        = '0;

        unique case (r_phase)
            PH_IDLE: begin
                if (!is_dig) begin
                    fail      = 1'b1;
                    fail_code = ERR_NO_PREFIX;
                end else if (limit == '0) begin
                    fail      = 1'b1;
                    fail_code = ERR_TOO_LONG;
                end else begin
                    n_digit_cnt  = DIGITS_W'(1);
                    n_len        = LENGTH_BITS'(dig);
                    n_ovf        = 1'b0;
                    n_first_zero = (dig == 4'd0);
                    n_phase      = PH_PREFIX;
                end
            end
            PH_PREFIX: begin
                if (is_dig) begin
                    if (r_digit_cnt >= limit) begin
                        fail      = 1'b1;
                        fail_code = ERR_TOO_LONG;
                    end else begin
                        n_digit_cnt = r_digit_cnt + DIGITS_W'(1);
                        if (mul_ovf) begin
                            n_len = '1;
                            n_ovf = 1'b1;
                        end else begin
                            n_len = len_mul[LENGTH_BITS-1:0];
                        end
                    end
                end else if (i_byte != CH_COLON) begin
                    fail      = 1'b1;
                    fail_code = ERR_NO_COLON;
                end else if ((r_digit_cnt > DIGITS_W'(1)) && r_first_zero) begin
                    fail      = 1'b1;
                    fail_code = ERR_LEAD_ZERO;
                end else if (r_ovf || (CMPW'(r_len) > CMPW'(i_cfg.max_payload))) begin
                    fail      = 1'b1;
                    fail_code = ERR_TOO_LARGE;
                end else begin
                    n_left  = r_len;
                    n_phase = (r_len == '0) ? PH_COMMA : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_left       = left_dec;
                o_res.kind   = KIND_DATA;
                o_res.data   = i_byte;
                o_res.last   = (left_dec == '0);
                if (left_dec == '0) begin
                    n_phase = PH_COMMA;
                end
            end
            PH_COMMA: begin
                if (i_byte != CH_COMMA) begin
                    fail      = 1'b1;
                    fail_code = ERR_NO_COMMA;
                end else begin
                    o_res.kind   = KIND_DONE;
                    o_res.fbytes = total[FB_W-1:0];
                    n_phase      = PH_IDLE;
                    n_digit_cnt  = '0;
                    n_len        = '0;
                    n_first_zero = 1'b0;
                    n_left       = '0;
                    n_ovf        = 1'b0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // Drop the frame and resync on any error
        if (fail) begin
            n_phase      = PH_IDLE;
            n_digit_cnt  = '0;
            n_len        = '0;
            n_first_zero = 1'b0;
            n_left       = '0;
            n_ovf        = 1'b0;
            o_res        = '0;
            o_res.kind   = KIND_ERR;
            o_res.err    = fail_code;
        end
    end

    // Hold frame state; advance once per processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_digit_cnt  <= '0;
            r_len        <= '0;
            r_first_zero <= 1'b0;
            r_left       <= '0;
            r_ovf        <= 1'b0;
        end else if (i_adv) begin
            r_phase      <= n_phase;
            r_digit_cnt  <= n_digit_cnt;
            r_len        <= n_len;
            r_first_zero <= n_first_zero;
            r_left       <= n_left;
            r_ovf        <= n_ovf;
        end
    end

    `ASSERT_NEXT(a_err_resync, i_clk, i_rst_n, i_adv && (o_res.kind == KIND_ERR), (r_phase == PH_IDLE) && (r_digit_cnt == '0), "error did not resync to idle")
    `ASSERT_IMPL(a_payload_left, i_clk, i_rst_n, r_phase == PH_PAYLOAD, r_left != '0, "payload phase with no bytes left")
    `ASSERT_IMPL(a_digit_bound, i_clk, i_rst_n, 1'b1, r_digit_cnt <= DIGIT_LIMIT, "digit count above nine")
    `ASSERT_NEXT(a_last_to_comma, i_clk, i_rst_n, i_adv && (o_res.kind == KIND_DATA) && o_res.last, r_phase == PH_COMMA, "last payload byte did not move to comma phase")

endmodule
